// ===== rtl/affra_pkg.sv =====
// shared types and constants for the aligned first-fit range allocator
package affra_pkg;

    localparam int MaxSlots = 16;
    localparam int MaxFree = 17;
    localparam int SlotBits = $clog2(MaxSlots);
    localparam int FreeBits = $clog2(MaxFree);
    localparam int FcBits = $clog2(MaxFree + 1);

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_BAD   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_BUSY     = 3'd2,
        ST_NOTREADY = 3'd3,
        ST_UNSUPP   = 3'd4,
        ST_NOMEM    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_PHYS = 3'd0,
        REG_VIRT = 3'd1,
        REG_SIZE = 3'd2,
        REG_CAPS = 3'd3,
        REG_EN   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] req_size;
        logic [4:0]  align_log2;
        logic [7:0]  req_flags;
        logic [31:0] handle_paddr;
        logic [31:0] handle_vaddr;
        logic [31:0] handle_cookie;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_paddr;
        logic [31:0] out_vaddr;
        logic [31:0] out_cookie;
        logic [7:0]  out_flags;
        logic [31:0] free_bytes;
    } rsp_t;

    // operations of the shared adder
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1
    } alu_op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] sum;
        logic        carry;
    } alu_rsp_t;

endpackage

// ===== rtl/affra_alu.sv =====
// shared 32-bit add/subtract unit with carry out
module affra_alu (
    input  affra_pkg::alu_req_t req,
    output affra_pkg::alu_rsp_t rsp
);
    import affra_pkg::*;

    logic [32:0] full;

    always_comb
    begin
        unique case (alu_op_t'(req.op))
            ALU_SUB: full = {1'b0, req.a} - {1'b0, req.b};
            default: full = {1'b0, req.a} + {1'b0, req.b};
        endcase
        rsp.sum = full[31:0];
        rsp.carry = full[32];
    end
endmodule

// ===== rtl/aligned_first_fit_range_allocator.sv =====
// top level of the aligned first-fit range allocator: sequencer, tables, shared adder
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------------------
//  request | start, busy, req (req_t)                  | item taken when start & !busy
//  result  | done, rsp (rsp_t)                         | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | write when cfg_valid & cfg_ready
//
// the sequencer walks the free table one entry at a time: an alloc pays up to four
// adder steps per entry through one shared adder, a query or a free position search
// takes one entry a cycle; splits and merges shift the table one entry a cycle
// rst_n clears control state, the config registers and slot valid bits
// the result receiver cannot stall; busy stays high until the done strobe
// config writes are taken only while idle and start is low, so a start wins
module aligned_first_fit_range_allocator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  affra_pkg::req_t      req,
    output logic                 done,
    output affra_pkg::rsp_t      rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import affra_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000000000000001,
        S_ACHK   = 16'b0000000000000010, // alloc pre-checks, slot pick
        S_AST    = 16'b0000000000000100, // start = base + off
        S_APAD   = 16'b0000000000001000, // pad, fit check
        S_AFIT   = 16'b0000000000010000, // size vs length - pad
        S_AVA    = 16'b0000000000100000, // virt alignment
        S_ATAKE  = 16'b0000000001000000, // split decision
        S_SHR    = 16'b0000000010000000, // shift table right one entry
        S_SHL    = 16'b0000000100000000, // shift table left one entry
        S_FCHK   = 16'b0000001000000000, // free checks
        S_FSLOT  = 16'b0000010000000000, // slot match scan
        S_FPOS   = 16'b0000100000000000, // find insert pos
        S_FMRG   = 16'b0001000000000000, // merge decision
        S_QSUM   = 16'b0010000000000000, // query sum
        S_FIN    = 16'b0100000000000000, // commit writes, after a shift if one was needed
        S_DONE   = 16'b1000000000000000
    } state_t;

    state_t state_reg;

    // configuration
    logic [31:0] phys_reg, virt_reg, size_reg;
    logic [7:0]  caps_reg;
    logic        en_reg;

    // tables
    logic [31:0] foff_reg [MaxFree];
    logic [31:0] flen_reg [MaxFree];
    logic [FcBits-1:0] fcnt_reg;
    logic [31:0] soff_reg [MaxSlots];
    logic [31:0] slen_reg [MaxSlots];
    logic [31:0] sck_reg [MaxSlots];
    logic [MaxSlots-1:0] sused_reg;
    logic [31:0] ncook_reg;

    // working registers
    req_t              q_reg;
    rsp_t              r_reg;
    logic [FcBits-1:0] idx_reg;      // free table walk index
    logic [FcBits-1:0] sh_reg;       // shift cursor
    logic [SlotBits:0] si_reg;       // slot scan index
    logic [SlotBits-1:0] slot_reg;
    logic [31:0]       t1_reg, t2_reg, off_reg;
    logic [2:0]        fin_reg;      // what to write in S_FIN, after any shift
    logic [31:0]       a1;
    logic [32:0]       a1w;

    localparam logic [2:0] FIN_SPLIT = 3'd0;
    localparam logic [2:0] FIN_INS   = 3'd1;
    localparam logic [2:0] FIN_ALLOC = 3'd2;
    localparam logic [2:0] FIN_JLR   = 3'd3;

    alu_req_t alu_q;
    alu_rsp_t alu_r;
    affra_alu u_alu (.req(alu_q), .rsp(alu_r));

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign a1w = (33'd1 << q_reg.align_log2) - 33'd1;
    assign a1 = a1w[31:0];

    logic [FreeBits-1:0] ix, ixm1, sh, shm1;
    assign ix = idx_reg[FreeBits-1:0];
    assign ixm1 = ix - 1'b1;
    assign sh = sh_reg[FreeBits-1:0];
    assign shm1 = sh - 1'b1;
    logic [SlotBits-1:0] si;
    assign si = si_reg[SlotBits-1:0];

    // first free slot, priority encode over the valid bits
    logic [SlotBits-1:0] fslot;
    logic                fslot_ok;
    always_comb
    begin
        fslot = '0;
        fslot_ok = 1'b0;
        for (int i = MaxSlots - 1; i >= 0; i--)
        begin
            if (!sused_reg[i])
            begin
                fslot = SlotBits'(i);
                fslot_ok = 1'b1;
            end
        end
    end

    // adder operand selection per state
    always_comb
    begin
        alu_q = '{op: ALU_ADD, a: 32'd0, b: 32'd0};
        unique case (state_reg)
            S_AST:   alu_q = '{op: ALU_ADD, a: phys_reg, b: foff_reg[ix]};
            S_APAD:  alu_q = '{op: ALU_ADD, a: t1_reg, b: a1};
            S_AFIT:  alu_q = '{op: ALU_SUB, a: flen_reg[ix], b: t2_reg};
            S_AVA:   alu_q = '{op: ALU_ADD, a: virt_reg, b: off_reg};
            S_FCHK:  alu_q = '{op: ALU_SUB, a: q_reg.handle_paddr, b: phys_reg};
            S_FPOS:  alu_q = '{op: ALU_ADD, a: foff_reg[ixm1], b: flen_reg[ixm1]};
            S_QSUM:  alu_q = '{op: ALU_ADD, a: t1_reg, b: flen_reg[ix]};
            default: alu_q = '{op: ALU_ADD, a: off_reg, b: q_reg.req_size};
        endcase
    end

    logic [31:0] cfg_top;
    assign cfg_top = ~phys_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phys_reg <= '0; virt_reg <= '0; size_reg <= '0;
            caps_reg <= '0; en_reg <= 1'b0;
            fcnt_reg <= '0; sused_reg <= '0; ncook_reg <= 32'd1;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        q_reg <= req;
                        r_reg <= '0;
                        idx_reg <= '0;
                        si_reg <= '0;
                        t1_reg <= '0;
                        unique case (action_t'(req.action))
                            ACT_ALLOC: state_reg <= S_ACHK;
                            ACT_FREE:  state_reg <= S_FCHK;
                            ACT_QUERY: state_reg <= S_QSUM;
                            default:
                            begin
                                r_reg.status <= ST_INVALID;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                    else if (cfg_valid)
                    begin
                        unique case (reg_idx_t'(cfg_index))
                            REG_PHYS: phys_reg <= cfg_data;
                            REG_VIRT: virt_reg <= cfg_data;
                            REG_SIZE: size_reg <= cfg_data;
                            REG_CAPS: caps_reg <= cfg_data[7:0];
                            REG_EN:
                            begin
                                if (!cfg_data[0])
                                    en_reg <= 1'b0;
                                else if (virt_reg != 0 && size_reg != 0 &&
                                         (size_reg - 32'd1) <= cfg_top &&
                                         !(en_reg && sused_reg != 0))
                                begin
                                    foff_reg[0] <= '0;
                                    flen_reg[0] <= size_reg;
                                    fcnt_reg <= FcBits'(1);
                                    sused_reg <= '0;
                                    ncook_reg <= 32'd1;
                                    en_reg <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ACHK:
                begin
                    slot_reg <= fslot;
                    state_reg <= S_AST;
                    if (q_reg.req_size == 0) begin r_reg.status <= ST_INVALID; state_reg <= S_DONE; end
                    else if (q_reg.handle_cookie != 0) begin r_reg.status <= ST_BUSY; state_reg <= S_DONE; end
                    else if (!en_reg) begin r_reg.status <= ST_NOTREADY; state_reg <= S_DONE; end
                    else if ((q_reg.req_flags & ~caps_reg) != 0) begin r_reg.status <= ST_UNSUPP; state_reg <= S_DONE; end
                    else if (!fslot_ok) begin r_reg.status <= ST_NOMEM; state_reg <= S_DONE; end
                end
                S_AST:
                begin
                    if (idx_reg >= fcnt_reg)
                    begin
                        r_reg.status <= ST_NOMEM;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        t1_reg <= alu_r.sum;
                        state_reg <= S_APAD;
                    end
                end
                S_APAD:
                begin
                    // start + a1 overflowing means no aligned address fits
                    if (alu_r.carry)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_AST;
                    end
                    else
                    begin
                        t2_reg <= (alu_r.sum & ~a1) - t1_reg;
                        state_reg <= S_AFIT;
                    end
                end
                S_AFIT:
                begin
                    if (alu_r.carry || q_reg.req_size > alu_r.sum)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_AST;
                    end
                    else
                    begin
                        off_reg <= foff_reg[ix] + t2_reg;
                        t1_reg <= alu_r.sum - q_reg.req_size; // after
                        state_reg <= S_AVA;
                    end
                end
                S_AVA:
                begin
                    if ((alu_r.sum & a1) != 0)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_AST;
                    end
                    else
                        state_reg <= S_ATAKE;
                end
                S_ATAKE:
                begin
                    // t2 = before, t1 = after, alu = off + size
                    if (t2_reg != 0 && t1_reg != 0)
                    begin
                        if (fcnt_reg >= FcBits'(MaxFree))
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_AST;
                        end
                        else
                        begin
                            sh_reg <= fcnt_reg;
                            fcnt_reg <= fcnt_reg + 1'b1;
                            fin_reg <= FIN_SPLIT;
                            state_reg <= S_SHR;
                        end
                    end
                    else
                    begin
                        fin_reg <= FIN_ALLOC;
                        if (t2_reg != 0)
                        begin
                            flen_reg[ix] <= t2_reg;
                            state_reg <= S_FIN;
                        end
                        else if (t1_reg != 0)
                        begin
                            foff_reg[ix] <= alu_r.sum;
                            flen_reg[ix] <= t1_reg;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            sh_reg <= idx_reg;
                            state_reg <= S_SHL;
                        end
                    end
                end
                S_SHR:
                begin
                    // open a hole at position sh_reg target
                    if ((fin_reg == FIN_SPLIT && sh_reg == idx_reg + 1'b1) ||
                        (fin_reg == FIN_INS && sh_reg == idx_reg))
                        state_reg <= S_FIN;
                    else
                    begin
                        foff_reg[sh] <= foff_reg[shm1];
                        flen_reg[sh] <= flen_reg[shm1];
                        sh_reg <= sh_reg - 1'b1;
                    end
                end
                S_SHL:
                begin
                    if (sh_reg + 1'b1 >= fcnt_reg)
                    begin
                        fcnt_reg <= fcnt_reg - 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        foff_reg[sh] <= foff_reg[sh + 1'b1];
                        flen_reg[sh] <= flen_reg[sh + 1'b1];
                        sh_reg <= sh_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_DONE;
                    unique case (fin_reg)
                        FIN_SPLIT:
                        begin
                            flen_reg[ix] <= t2_reg;
                            foff_reg[ix + 1'b1] <= alu_r.sum;
                            flen_reg[ix + 1'b1] <= t1_reg;
                            fin_reg <= FIN_ALLOC;
                            state_reg <= S_FIN;
                        end
                        FIN_ALLOC:
                        begin
                            // cookie, skipping zero
                            logic [31:0] ck;
                            ck = (ncook_reg == 0) ? 32'd1 : ncook_reg;
                            ncook_reg <= ck + 32'd1;
                            soff_reg[slot_reg] <= off_reg;
                            slen_reg[slot_reg] <= q_reg.req_size;
                            sck_reg[slot_reg] <= ck;
                            sused_reg[slot_reg] <= 1'b1;
                            r_reg.status <= ST_OK;
                            r_reg.out_paddr <= phys_reg + off_reg;
                            r_reg.out_vaddr <= virt_reg + off_reg;
                            r_reg.out_cookie <= ck;
                            r_reg.out_flags <= q_reg.req_flags | caps_reg;
                        end
                        FIN_INS:
                        begin
                            foff_reg[ix] <= off_reg;
                            flen_reg[ix] <= q_reg.req_size;
                            sused_reg[slot_reg] <= 1'b0;
                        end
                        default: // free done via merge
                            sused_reg[slot_reg] <= 1'b0;
                    endcase
                end
                S_FCHK:
                begin
                    off_reg <= alu_r.sum;
                    state_reg <= S_FSLOT;
                    if (q_reg.handle_cookie == 0 || q_reg.handle_vaddr == 0 || !en_reg ||
                        alu_r.carry || alu_r.sum > size_reg ||
                        q_reg.req_size > size_reg - alu_r.sum ||
                        q_reg.handle_vaddr != virt_reg + alu_r.sum)
                    begin
                        r_reg.status <= ST_INVALID;
                        state_reg <= S_DONE;
                    end
                end
                S_FSLOT:
                begin
                    if (si_reg == (SlotBits + 1)'(MaxSlots))
                    begin
                        r_reg.status <= ST_INVALID;
                        state_reg <= S_DONE;
                    end
                    else if (sused_reg[si] && sck_reg[si] == q_reg.handle_cookie &&
                             soff_reg[si] == off_reg && slen_reg[si] == q_reg.req_size)
                    begin
                        slot_reg <= si;
                        state_reg <= S_FPOS;
                    end
                    else
                        si_reg <= si_reg + 1'b1;
                end
                S_FPOS:
                begin
                    if (idx_reg < fcnt_reg && foff_reg[ix] < off_reg)
                        idx_reg <= idx_reg + 1'b1;
                    else
                    begin
                        // left end via adder (entry idx-1)
                        t1_reg <= alu_r.sum;
                        state_reg <= S_FMRG;
                    end
                end
                S_FMRG:
                begin
                    logic hl, hr, jl, jr;
                    logic [31:0] endv;
                    endv = alu_r.sum;
                    hl = idx_reg != 0;
                    hr = idx_reg < fcnt_reg;
                    jl = hl && t1_reg == off_reg;
                    jr = hr && endv == foff_reg[ix];
                    r_reg.status <= ST_OK;
                    fin_reg <= FIN_JLR;
                    state_reg <= S_FIN;
                    if ((hl && t1_reg > off_reg) || (hr && endv > foff_reg[ix]))
                    begin
                        r_reg.status <= ST_INVALID;
                        state_reg <= S_DONE;
                    end
                    else if (jl && jr)
                    begin
                        flen_reg[ixm1] <= flen_reg[ixm1] + q_reg.req_size + flen_reg[ix];
                        sh_reg <= idx_reg;
                        state_reg <= S_SHL;
                    end
                    else if (jl)
                        flen_reg[ixm1] <= flen_reg[ixm1] + q_reg.req_size;
                    else if (jr)
                    begin
                        foff_reg[ix] <= off_reg;
                        flen_reg[ix] <= flen_reg[ix] + q_reg.req_size;
                    end
                    else if (fcnt_reg >= FcBits'(MaxFree))
                    begin
                        r_reg.status <= ST_NOMEM;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sh_reg <= fcnt_reg;
                        fcnt_reg <= fcnt_reg + 1'b1;
                        fin_reg <= FIN_INS;
                        state_reg <= S_SHR;
                    end
                end
                S_QSUM:
                begin
                    if (!en_reg || idx_reg >= fcnt_reg)
                    begin
                        r_reg.free_bytes <= en_reg ? t1_reg : 32'd0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        t1_reg <= alu_r.sum;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp = r_reg;

    // free table never exceeds its depth
    assert property (@(posedge clk) disable iff (!rst_n) fcnt_reg <= FcBits'(MaxFree))
        else $error("free count overflow");
    // done only follows the done state
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(state_reg) == S_DONE)
        else $error("stray done");
    // block is idle again while done strobes
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("busy during done");
    // an item and a register write are never taken at the same edge
    assert property (@(posedge clk) disable iff (!rst_n)
                     !(cfg_valid && cfg_ready && start && !busy))
        else $error("item and config write together");
endmodule
